@@ rtl/cpc_pkg.sv @@
`default_nettype none

package cpc_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int POS_WIDTH_DEF = 24;
    localparam int MASS_W        = 16;
    localparam int RAD_W         = 10;
    localparam int NORM_FRAC     = 12;
    localparam int HALF_SHIFT    = 1;

endpackage

`default_nettype wire

@@ rtl/cpc_pair_if.sv @@
`default_nettype none

interface cpc_pair_if
    import cpc_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) ();

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] first_pos_x;
    logic signed [POS_WIDTH-1:0] first_pos_y;
    logic signed [POS_WIDTH-1:0] first_vel_x;
    logic signed [POS_WIDTH-1:0] first_vel_y;
    logic        [MASS_W-1:0]    first_mass;
    logic        [RAD_W-1:0]     first_rad;
    logic signed [POS_WIDTH-1:0] second_pos_x;
    logic signed [POS_WIDTH-1:0] second_pos_y;
    logic signed [POS_WIDTH-1:0] second_vel_x;
    logic signed [POS_WIDTH-1:0] second_vel_y;
    logic        [MASS_W-1:0]    second_mass;
    logic        [RAD_W-1:0]     second_rad;

    modport source (
        output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
        first_rad, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
        second_mass, second_rad,
        input  ready
    );

    modport sink (
        input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
        first_rad, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
        second_mass, second_rad,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/cpc_result_if.sv @@
`default_nettype none

interface cpc_result_if
    import cpc_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) ();

    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic signed [POS_WIDTH-1:0] new_first_pos_x;
    logic signed [POS_WIDTH-1:0] new_first_pos_y;
    logic signed [POS_WIDTH-1:0] new_first_vel_x;
    logic signed [POS_WIDTH-1:0] new_first_vel_y;
    logic signed [POS_WIDTH-1:0] new_second_pos_x;
    logic signed [POS_WIDTH-1:0] new_second_pos_y;
    logic signed [POS_WIDTH-1:0] new_second_vel_x;
    logic signed [POS_WIDTH-1:0] new_second_vel_y;

    modport source (
        output valid, hit, new_first_pos_x, new_first_pos_y, new_first_vel_x,
        new_first_vel_y, new_second_pos_x, new_second_pos_y, new_second_vel_x,
        new_second_vel_y,
        input  ready
    );

    modport sink (
        input  valid, hit, new_first_pos_x, new_first_pos_y, new_first_vel_x,
        new_first_vel_y, new_second_pos_x, new_second_pos_y, new_second_vel_x,
        new_second_vel_y,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/cpc_sqrt.sv @@
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module cpc_sqrt
    import cpc_pkg::*;
#(
    parameter int R_W = RAD_W + 1 + FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [2*R_W-1:0]   rad,
    output logic      [R_W-1:0]     root
);

    localparam int RM = R_W + 3;

    logic [RM-1:0]      rem_reg  [R_W];
    logic [R_W-1:0]     root_reg [R_W];
    logic [2*R_W-1:0]   rad_reg  [R_W];

    for (genvar i = 0; i < R_W; i++) begin : g_stage
        logic [RM-1:0]    rem_in;
        logic [R_W-1:0]   root_in;
        logic [2*R_W-1:0] rad_in;
        logic [RM-1:0]    part;
        logic [RM-1:0]    trial;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        always_comb
        begin
            part  = {rem_in[RM-3:0], rad_in[2*R_W-1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (part >= trial)
                begin
                    rem_reg[i]  <= part - trial;
                    root_reg[i] <= {root_in[R_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= part;
                    root_reg[i] <= {root_in[R_W-2:0], 1'b0};
                end
                rad_reg[i] <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[R_W-1];

endmodule

`default_nettype wire

@@ rtl/cpc_div.sv @@
`default_nettype none

// Pipelined restoring divider for unsigned operands. It develops the low Q_W
// quotient bits, one per stage; ovf flags a quotient that needs more bits.
module cpc_div
    import cpc_pkg::*;
#(
    parameter int N_W = 32,
    parameter int D_W = MASS_W,
    parameter int Q_W = POS_WIDTH_DEF + 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [N_W-1:0]   num,
    input  wire logic [D_W-1:0]   den,
    output logic      [Q_W-1:0]   quo,
    output logic                  ovf
);

    localparam int HW = N_W + D_W;

    logic [HW-1:0]  hi;
    logic [D_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0] lo_reg  [Q_W];
    logic [Q_W-1:0] quo_reg [Q_W];
    logic [D_W-1:0] den_reg [Q_W];
    logic           ovf_reg [Q_W];

    assign hi = HW'(num >> Q_W);

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] lo_in;
        logic [Q_W-1:0] quo_in;
        logic [D_W-1:0] den_in;
        logic           ovf_in;
        logic [D_W:0]   part;
        logic           take;

        if (i == 0) begin : g_first
            assign rem_in = hi[D_W-1:0];
            assign lo_in  = num[Q_W-1:0];
            assign quo_in = '0;
            assign den_in = den;
            assign ovf_in = (hi >= HW'(den));
        end
        else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
        end

        always_comb
        begin
            part = {rem_in, lo_in[Q_W-1]};
            take = (part >= {1'b0, den_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? D_W'(part - {1'b0, den_in}) : part[D_W-1:0];
                lo_reg[i]  <= lo_in << 1;
                quo_reg[i] <= {quo_in[Q_W-2:0], take};
                den_reg[i] <= den_in;
                ovf_reg[i] <= ovf_in;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];
    assign ovf = ovf_reg[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/cpc_skid.sv @@
`default_nettype none

// Two-entry output queue. full is registered, so the pipeline enable does not
// depend combinationally on the downstream ready.
module cpc_skid #(
    parameter int W = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [W-1:0]   data,
    output logic                full,
    output logic                valid,
    input  wire logic           ready,
    output logic      [W-1:0]   head
);

    logic [W-1:0] ent_reg [2];
    logic         wr_reg;
    logic         rd_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         pop;

    assign pop      = valid && ready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= data;
    end

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = ent_reg[rd_reg];

endmodule

`default_nettype wire

@@ rtl/circle_pair_collision_response.sv @@
// Collision response for a pair of circles.
// pair carries one transaction per circle pair (position, velocity, mass,
// radius of each); result returns one transaction per pair with the hit
// flag and the updated, saturated positions and velocities. Both channels use
// valid/ready and move a transaction when both are high.
// The pipeline is made of the square-root pipeline (one root bit per stage),
// the normal dividers (13 stages), the impulse dividers (POS_WIDTH + 1 stages),
// seven arithmetic stages and the output queue.
// Throughput is one pair per cycle while the output queue is not full: every
// stage is registered and a new pair can enter on each clock.
// Reset clears all valid bits and the output queue; no result is pending after it.
// When the receiver stalls, results collect in a two-entry output queue; once it
// is full the whole pipeline holds and pair.ready drops, without losing or
// repeating a transaction.
`default_nettype none

module circle_pair_collision_response
    import cpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cpc_pair_if.sink      pair,
    cpc_result_if.source  result
);

    localparam int P     = POS_WIDTH;
    localparam int RS_W  = RAD_W + 1 + FRAC_BITS;
    localparam int D2_W  = 2 * RS_W;
    localparam int CW    = (P + 1 > RS_W) ? P + 1 : RS_W;
    localparam int NQ_W  = NORM_FRAC + 1;
    localparam int N_W   = NORM_FRAC + 2;
    localparam int ND_W  = RS_W + NORM_FRAC;
    localparam int M_W   = P + MASS_W + 1;
    localparam int DP_W  = M_W + N_W;
    localparam int DT_W  = M_W + 2;
    localparam int PD_W  = DT_W + N_W;
    localparam int IX_W  = M_W + 1;
    localparam int IQ_W  = P + 1;
    localparam int OV_W  = RS_W + NQ_W;
    localparam int W_SUM = ((P > RS_W) ? P : RS_W) + 3;

    typedef struct packed {
        logic signed [P-1:0]    p1x;
        logic signed [P-1:0]    p1y;
        logic signed [P-1:0]    v1x;
        logic signed [P-1:0]    v1y;
        logic signed [P-1:0]    p2x;
        logic signed [P-1:0]    p2y;
        logic signed [P-1:0]    v2x;
        logic signed [P-1:0]    v2y;
        logic [MASS_W-1:0]      m1;
        logic [MASS_W-1:0]      m2;
        logic [RS_W-1:0]        rs;
        logic                   sgx;
        logic                   sgy;
        logic [CW-1:0]          ax;
        logic [CW-1:0]          ay;
        logic signed [M_W-1:0]  pv1x;
        logic signed [M_W-1:0]  pv1y;
        logic signed [M_W-1:0]  pv2x;
        logic signed [M_W-1:0]  pv2y;
        logic [RS_W-1:0]        axn;
        logic [RS_W-1:0]        ayn;
        logic [D2_W-1:0]        sqx;
        logic [D2_W-1:0]        sqy;
        logic [D2_W-1:0]        rs2;
        logic signed [M_W-1:0]  mx;
        logic signed [M_W-1:0]  my;
        logic                   inr;
        logic                   hit;
        logic                   apply;
        logic [D2_W-1:0]        d2;
        logic [RS_W-1:0]        d;
        logic signed [N_W-1:0]  nx;
        logic signed [N_W-1:0]  ny;
        logic signed [DP_W-1:0] prx;
        logic signed [DP_W-1:0] pry;
        logic [OV_W-1:0]        ovx;
        logic [OV_W-1:0]        ovy;
        logic [RS_W-1:0]        sx;
        logic [RS_W-1:0]        sy;
        logic signed [DT_W-1:0] dot;
        logic signed [PD_W-1:0] pdx;
        logic signed [PD_W-1:0] pdy;
        logic [IX_W-1:0]        ixm;
        logic [IX_W-1:0]        iym;
        logic                   ixs;
        logic                   iys;
    } item_t;

    typedef struct packed {
        logic                hit;
        logic signed [P-1:0] p1x;
        logic signed [P-1:0] p1y;
        logic signed [P-1:0] v1x;
        logic signed [P-1:0] v1y;
        logic signed [P-1:0] p2x;
        logic signed [P-1:0] p2y;
        logic signed [P-1:0] v2x;
        logic signed [P-1:0] v2y;
    } res_t;

    function automatic logic signed [P-1:0] sat_pos(input logic signed [W_SUM-1:0] v);
        logic signed [P-1:0] r;
        if (v[W_SUM-1:P-1] == '0 || v[W_SUM-1:P-1] == '1)
            r = v[P-1:0];
        else if (v[W_SUM-1])
            r = {1'b1, {(P-1){1'b0}}};
        else
            r = {1'b0, {(P-1){1'b1}}};
        return r;
    endfunction

    logic en;
    logic q_full;

    assign en         = !q_full;
    assign pair.ready = en;

    // ---------------- front stages: differences, squares, hit test
    item_t a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic  a_v_reg, b_v_reg, c_v_reg;

    logic signed [P:0]  dx, dy;
    logic [P:0]         ax_u, ay_u;
    logic [MASS_W-1:0]  m1_fix, m2_fix;
    logic [RAD_W:0]     r_sum;

    always_comb
    begin
        m1_fix = (pair.first_mass == '0) ? MASS_W'(1) : pair.first_mass;
        m2_fix = (pair.second_mass == '0) ? MASS_W'(1) : pair.second_mass;
        dx     = (P+1)'(pair.second_pos_x) - (P+1)'(pair.first_pos_x);
        dy     = (P+1)'(pair.second_pos_y) - (P+1)'(pair.first_pos_y);
        ax_u   = dx[P] ? (P+1)'(-dx) : dx;
        ay_u   = dy[P] ? (P+1)'(-dy) : dy;
        r_sum  = (RAD_W+1)'(pair.first_rad) + (RAD_W+1)'(pair.second_rad);

        a_next      = '0;
        a_next.p1x  = pair.first_pos_x;
        a_next.p1y  = pair.first_pos_y;
        a_next.v1x  = pair.first_vel_x;
        a_next.v1y  = pair.first_vel_y;
        a_next.p2x  = pair.second_pos_x;
        a_next.p2y  = pair.second_pos_y;
        a_next.v2x  = pair.second_vel_x;
        a_next.v2y  = pair.second_vel_y;
        a_next.m1   = m1_fix;
        a_next.m2   = m2_fix;
        a_next.rs   = RS_W'(r_sum) << FRAC_BITS;
        a_next.sgx  = dx[P];
        a_next.sgy  = dy[P];
        a_next.ax   = CW'(ax_u);
        a_next.ay   = CW'(ay_u);
        a_next.pv1x = pair.first_vel_x * $signed({1'b0, m1_fix});
        a_next.pv1y = pair.first_vel_y * $signed({1'b0, m1_fix});
        a_next.pv2x = pair.second_vel_x * $signed({1'b0, m2_fix});
        a_next.pv2y = pair.second_vel_y * $signed({1'b0, m2_fix});
    end

    always_comb
    begin
        b_next     = a_reg;
        b_next.inr = (a_reg.ax < CW'(a_reg.rs)) && (a_reg.ay < CW'(a_reg.rs));
        b_next.axn = a_reg.ax[RS_W-1:0];
        b_next.ayn = a_reg.ay[RS_W-1:0];
        b_next.sqx = a_reg.ax[RS_W-1:0] * a_reg.ax[RS_W-1:0];
        b_next.sqy = a_reg.ay[RS_W-1:0] * a_reg.ay[RS_W-1:0];
        b_next.rs2 = a_reg.rs * a_reg.rs;
        b_next.mx  = a_reg.pv2x - a_reg.pv1x;
        b_next.my  = a_reg.pv2y - a_reg.pv1y;
    end

    logic [D2_W:0] d2_sum;

    always_comb
    begin
        d2_sum       = {1'b0, b_reg.sqx} + {1'b0, b_reg.sqy};
        c_next       = b_reg;
        c_next.hit   = b_reg.inr && (d2_sum < {1'b0, b_reg.rs2});
        c_next.apply = c_next.hit && (d2_sum != '0);
        c_next.d2    = d2_sum[D2_W-1:0];
    end

    // ---------------- square root of the squared distance
    logic [RS_W-1:0] root;
    item_t           sq_line_reg [RS_W];
    logic [RS_W-1:0] sq_v_reg;
    item_t           sq_end;

    cpc_sqrt #(
        .R_W (RS_W)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (c_reg.d2),
        .root (root)
    );

    assign sq_end = sq_line_reg[RS_W-1];

    // ---------------- unit normal: |d| << 12 / distance
    item_t            nd_in;
    item_t            nd_line_reg [NQ_W];
    logic [NQ_W-1:0]  nd_v_reg;
    item_t            nd_end;
    logic [NQ_W-1:0]  nxq, nyq;
    logic             nx_ovf, ny_ovf;

    always_comb
    begin
        nd_in   = sq_end;
        nd_in.d = root;
    end

    cpc_div #(
        .N_W (ND_W),
        .D_W (RS_W),
        .Q_W (NQ_W)
    ) u_div_nx (
        .clk (clk),
        .en  (en),
        .num ({sq_end.axn, NORM_FRAC'(0)}),
        .den (root),
        .quo (nxq),
        .ovf (nx_ovf)
    );

    cpc_div #(
        .N_W (ND_W),
        .D_W (RS_W),
        .Q_W (NQ_W)
    ) u_div_ny (
        .clk (clk),
        .en  (en),
        .num ({sq_end.ayn, NORM_FRAC'(0)}),
        .den (root),
        .quo (nyq),
        .ovf (ny_ovf)
    );

    assign nd_end = nd_line_reg[NQ_W-1];

    // ---------------- projection and separation arithmetic
    item_t m1_reg, m1_next, m2_reg, m2_next, m3_reg, m3_next, m4_reg, m4_next;
    logic  m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg;

    logic [NQ_W-1:0]        nxm, nym;
    logic signed [N_W-1:0]  nx_v, ny_v;
    logic [RS_W-1:0]        ov;

    always_comb
    begin
        nxm  = nx_ovf ? '1 : nxq;
        nym  = ny_ovf ? '1 : nyq;
        nx_v = nd_end.sgx ? -N_W'(nxm) : N_W'(nxm);
        ny_v = nd_end.sgy ? -N_W'(nym) : N_W'(nym);
        ov   = nd_end.rs - nd_end.d;

        m1_next     = nd_end;
        m1_next.nx  = nx_v;
        m1_next.ny  = ny_v;
        m1_next.prx = nd_end.mx * nx_v;
        m1_next.pry = nd_end.my * ny_v;
        m1_next.ovx = ov * nxm;
        m1_next.ovy = ov * nym;
    end

    logic signed [DP_W:0] dsum;
    logic [DP_W:0]        dsum_mag;
    logic [DP_W:0]        dsum_sh;

    always_comb
    begin
        dsum     = (DP_W+1)'(m1_reg.prx) + (DP_W+1)'(m1_reg.pry);
        dsum_mag = dsum[DP_W] ? (DP_W+1)'(-dsum) : dsum;
        dsum_sh  = dsum_mag >> NORM_FRAC;

        m2_next     = m1_reg;
        m2_next.dot = dsum[DP_W] ? -DT_W'(dsum_sh) : DT_W'(dsum_sh);
        m2_next.sx  = RS_W'(m1_reg.ovx >> (NORM_FRAC + HALF_SHIFT));
        m2_next.sy  = RS_W'(m1_reg.ovy >> (NORM_FRAC + HALF_SHIFT));
    end

    always_comb
    begin
        m3_next     = m2_reg;
        m3_next.pdx = m2_reg.dot * m2_reg.nx;
        m3_next.pdy = m2_reg.dot * m2_reg.ny;
    end

    logic [PD_W-1:0] pdx_mag, pdy_mag;

    always_comb
    begin
        pdx_mag     = m3_reg.pdx[PD_W-1] ? PD_W'(-m3_reg.pdx) : m3_reg.pdx;
        pdy_mag     = m3_reg.pdy[PD_W-1] ? PD_W'(-m3_reg.pdy) : m3_reg.pdy;
        m4_next     = m3_reg;
        m4_next.ixm = IX_W'(pdx_mag >> NORM_FRAC);
        m4_next.iym = IX_W'(pdy_mag >> NORM_FRAC);
        m4_next.ixs = m3_reg.pdx[PD_W-1];
        m4_next.iys = m3_reg.pdy[PD_W-1];
    end

    // ---------------- impulse divided by each mass
    item_t           id_line_reg [IQ_W];
    logic [IQ_W-1:0] id_v_reg;
    item_t           id_end;
    logic [IQ_W-1:0] q1x, q1y, q2x, q2y;
    logic            o1x, o1y, o2x, o2y;

    cpc_div #(.N_W (IX_W), .D_W (MASS_W), .Q_W (IQ_W)) u_div_1x (
        .clk (clk), .en (en), .num (m4_reg.ixm), .den (m4_reg.m1), .quo (q1x), .ovf (o1x)
    );

    cpc_div #(.N_W (IX_W), .D_W (MASS_W), .Q_W (IQ_W)) u_div_1y (
        .clk (clk), .en (en), .num (m4_reg.iym), .den (m4_reg.m1), .quo (q1y), .ovf (o1y)
    );

    cpc_div #(.N_W (IX_W), .D_W (MASS_W), .Q_W (IQ_W)) u_div_2x (
        .clk (clk), .en (en), .num (m4_reg.ixm), .den (m4_reg.m2), .quo (q2x), .ovf (o2x)
    );

    cpc_div #(.N_W (IX_W), .D_W (MASS_W), .Q_W (IQ_W)) u_div_2y (
        .clk (clk), .en (en), .num (m4_reg.iym), .den (m4_reg.m2), .quo (q2y), .ovf (o2y)
    );

    assign id_end = id_line_reg[IQ_W-1];

    // ---------------- final update and saturation
    // A quotient too wide for IQ_W bits saturates the velocity either way,
    // so it is clamped to all ones.
    logic [IQ_W-1:0]          c1x, c1y, c2x, c2y;
    logic signed [W_SUM-1:0]  dv1x, dv1y, dv2x, dv2y, dsx, dsy;
    res_t                     res;

    always_comb
    begin
        c1x  = o1x ? '1 : q1x;
        c1y  = o1y ? '1 : q1y;
        c2x  = o2x ? '1 : q2x;
        c2y  = o2y ? '1 : q2y;
        dv1x = id_end.ixs ? -W_SUM'(c1x) : W_SUM'(c1x);
        dv1y = id_end.iys ? -W_SUM'(c1y) : W_SUM'(c1y);
        dv2x = id_end.ixs ? -W_SUM'(c2x) : W_SUM'(c2x);
        dv2y = id_end.iys ? -W_SUM'(c2y) : W_SUM'(c2y);
        dsx  = id_end.sgx ? -W_SUM'(id_end.sx) : W_SUM'(id_end.sx);
        dsy  = id_end.sgy ? -W_SUM'(id_end.sy) : W_SUM'(id_end.sy);

        res.hit = id_end.hit;
        if (id_end.apply)
        begin
            res.v1x = sat_pos(W_SUM'(id_end.v1x) + dv1x);
            res.v1y = sat_pos(W_SUM'(id_end.v1y) + dv1y);
            res.v2x = sat_pos(W_SUM'(id_end.v2x) - dv2x);
            res.v2y = sat_pos(W_SUM'(id_end.v2y) - dv2y);
            res.p1x = sat_pos(W_SUM'(id_end.p1x) - dsx);
            res.p1y = sat_pos(W_SUM'(id_end.p1y) - dsy);
            res.p2x = sat_pos(W_SUM'(id_end.p2x) + dsx);
            res.p2y = sat_pos(W_SUM'(id_end.p2y) + dsy);
        end
        else
        begin
            res.v1x = id_end.v1x;
            res.v1y = id_end.v1y;
            res.v2x = id_end.v2x;
            res.v2y = id_end.v2y;
            res.p1x = id_end.p1x;
            res.p1y = id_end.p1y;
            res.p2x = id_end.p2x;
            res.p2y = id_end.p2y;
        end
    end

    // ---------------- stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            sq_v_reg <= '0;
            nd_v_reg <= '0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
            id_v_reg <= '0;
        end
        else if (en)
        begin
            a_v_reg  <= pair.valid;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            sq_v_reg <= {sq_v_reg[RS_W-2:0], c_v_reg};
            nd_v_reg <= {nd_v_reg[NQ_W-2:0], sq_v_reg[RS_W-1]};
            m1_v_reg <= nd_v_reg[NQ_W-1];
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
            id_v_reg <= {id_v_reg[IQ_W-2:0], m4_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            c_reg  <= c_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
            sq_line_reg[0] <= c_reg;
            for (int k = 1; k < RS_W; k++)
                sq_line_reg[k] <= sq_line_reg[k-1];
            nd_line_reg[0] <= nd_in;
            for (int k = 1; k < NQ_W; k++)
                nd_line_reg[k] <= nd_line_reg[k-1];
            id_line_reg[0] <= m4_reg;
            for (int k = 1; k < IQ_W; k++)
                id_line_reg[k] <= id_line_reg[k-1];
        end
    end

    // ---------------- output queue
    res_t q_head;

    cpc_skid #(
        .W ($bits(res_t))
    ) u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (en && id_v_reg[IQ_W-1]),
        .data  (res),
        .full  (q_full),
        .valid (result.valid),
        .ready (result.ready),
        .head  (q_head)
    );

    assign result.hit              = q_head.hit;
    assign result.new_first_pos_x  = q_head.p1x;
    assign result.new_first_pos_y  = q_head.p1y;
    assign result.new_first_vel_x  = q_head.v1x;
    assign result.new_first_vel_y  = q_head.v1y;
    assign result.new_second_pos_x = q_head.p2x;
    assign result.new_second_pos_y = q_head.p2y;
    assign result.new_second_vel_x = q_head.v2x;
    assign result.new_second_vel_y = q_head.v2y;

    // ---------------- assertions
    // A colliding pair has a distance below the radius sum.
    a_root_below_rs: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_v_reg[RS_W-1] && sq_end.hit) |-> (root < sq_end.rs))
        else $error("square root not below radius sum for a colliding pair");

    // Separated centers must give a nonzero distance, or the normal divides by zero.
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_v_reg[RS_W-1] && sq_end.apply) |-> (root != '0))
        else $error("zero distance for a pair with separate centers");

    // Normal components never exceed one in magnitude.
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nd_v_reg[NQ_W-1] && nd_end.apply) |-> (!nx_ovf && !ny_ovf))
        else $error("normal division overflow");

endmodule

`default_nettype wire
